// File: sv/tas_pkg.sv
package tas_pkg;

  // item kinds
  localparam logic [1:0] KIND_DEFINE = 2'd0;
  localparam logic [1:0] KIND_ORDER  = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  // fixed field widths
  localparam int SLOT_W   = 3;
  localparam int TILE_W   = 16;
  localparam int FRAMES_W = 7;
  localparam int TIME_W   = 16;
  localparam int OLEN_W   = 6;
  localparam int OPOS_W   = 5;
  localparam int OVAL_W   = 8;
  localparam int FIDX_W   = 6;
  // position never exceeds the 7-bit frame count
  localparam int POS_W    = 7;
  // slot index inside the chain, covers the largest slot count
  localparam int CELL_ID_W = 6;

  typedef struct packed {
    logic [1:0]          kind;
    logic [SLOT_W-1:0]   slot;
    logic [TILE_W-1:0]   tile_index;
    logic [FRAMES_W-1:0] frame_count;
    logic [TIME_W-1:0]   frame_time;
    logic [OLEN_W-1:0]   order_length;
    logic [OPOS_W-1:0]   order_position;
    logic [OVAL_W-1:0]   order_value;
  } in_word_t;

  typedef struct packed {
    logic                updated;
    logic [SLOT_W-1:0]   source_slot;
    logic [TILE_W-1:0]   target_tile;
    logic [FIDX_W-1:0]   frame_index;
    logic                last;
  } out_word_t;

  // slot commands broadcast to every cell
  typedef struct packed {
    logic                define_en;
    logic                clear_en;
    logic [SLOT_W-1:0]   slot;
    logic [TILE_W-1:0]   tile;
    logic [FRAMES_W-1:0] frames;
    logic [TIME_W-1:0]   period;
    logic [OLEN_W-1:0]   olen;
  } cell_cmd_t;

  // advance record from the cell that holds the token
  typedef struct packed {
    logic                 valid;
    logic [CELL_ID_W-1:0] slot;
    logic [TILE_W-1:0]    tile;
    logic [FRAMES_W-1:0]  frames;
    logic                 ordered;
    logic [POS_W-1:0]     pos;
  } slot_rec_t;

  // order table write
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [OPOS_W-1:0] position;
    logic [OVAL_W-1:0] value;
  } ord_wr_t;

endpackage

// File: sv/tas_cell.sv
module tas_cell #(
  parameter int SLOT_ID = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tas_pkg::cell_cmd_t  cmd,
  input  logic                tok_in,
  output logic                tok_out,
  output tas_pkg::slot_rec_t  rec
);

  logic                           valid_r;
  logic [tas_pkg::TILE_W-1:0]     tile_r;
  logic [tas_pkg::FRAMES_W-1:0]   frames_r;
  logic [tas_pkg::TIME_W-1:0]     period_r;
  logic [tas_pkg::OLEN_W-1:0]     olen_r;
  logic [tas_pkg::TIME_W-1:0]     count_r;
  logic [tas_pkg::POS_W-1:0]      pos_r;
  logic                           tok_r;

  logic                           hit;
  logic                           active;
  logic [tas_pkg::TIME_W-1:0]     count_inc;
  logic                           adv;
  logic [tas_pkg::FRAMES_W-1:0]   total;
  logic [tas_pkg::POS_W:0]        pos_inc;
  logic [tas_pkg::POS_W-1:0]      pos_nxt;

  assign hit    = cmd.define_en &&
                  (tas_pkg::CELL_ID_W'(cmd.slot) == tas_pkg::CELL_ID_W'(SLOT_ID));
  assign active = tok_in && valid_r;

  // count one tick, advance when the period is reached
  assign count_inc = count_r + 1'b1;
  assign adv       = !(count_inc < period_r);
  assign total     = (olen_r != '0) ? tas_pkg::FRAMES_W'(olen_r) : frames_r;
  assign pos_inc   = {1'b0, pos_r} + 1'b1;
  assign pos_nxt   = (pos_inc >= {1'b0, total}) ? '0 : pos_inc[tas_pkg::POS_W-1:0];

  always_comb begin
    rec = '0;
    if (active && adv) begin
      rec.valid   = 1'b1;
      rec.slot    = tas_pkg::CELL_ID_W'(SLOT_ID);
      rec.tile    = tile_r;
      rec.frames  = frames_r;
      rec.ordered = (olen_r != '0);
      rec.pos     = pos_nxt;
    end
  end

  assign tok_out = tok_r;

  // slot state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      count_r <= '0;
      pos_r   <= '0;
      tok_r   <= 1'b0;
    end else begin
      tok_r <= tok_in;
      if (cmd.clear_en) begin
        valid_r <= 1'b0;
        count_r <= '0;
        pos_r   <= '0;
      end else if (hit) begin
        valid_r <= 1'b1;
        count_r <= '0;
        pos_r   <= '0;
      end else if (active) begin
        if (adv) begin
          count_r <= '0;
          pos_r   <= pos_nxt;
        end else begin
          count_r <= count_inc;
        end
      end
    end
  end

  // slot parameters, no reset
  always_ff @(posedge clk) begin
    if (hit) begin
      tile_r   <= cmd.tile;
      frames_r <= cmd.frames;
      period_r <= cmd.period;
      olen_r   <= cmd.olen;
    end
  end

endmodule

// File: sv/tas_emit.sv
module tas_emit #(
  parameter int NUM_SLOTS   = 8,
  parameter int ORDER_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tas_pkg::ord_wr_t    ord_wr,
  input  tas_pkg::slot_rec_t  rec,
  input  logic                chain_end,
  output logic                out_strobe,
  output tas_pkg::out_word_t  out_word,
  output logic                done
);

  localparam int MEM_DEPTH = NUM_SLOTS * ORDER_DEPTH;
  localparam int MAW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  logic [tas_pkg::OVAL_W-1:0]     order_mem [MEM_DEPTH];
  logic [tas_pkg::OVAL_W-1:0]     rdata_r;
  logic [MAW-1:0]                 waddr;
  logic [MAW-1:0]                 raddr;

  logic                           s1_valid_r;
  logic [tas_pkg::SLOT_W-1:0]     s1_slot_r;
  logic [tas_pkg::TILE_W-1:0]     s1_tile_r;
  logic [tas_pkg::FRAMES_W-1:0]   s1_frames_r;
  logic                           s1_ordered_r;
  logic [tas_pkg::POS_W-1:0]      s1_pos_r;
  logic                           end_d_r;

  logic                           pend_valid_r;
  tas_pkg::out_word_t             pend_r;
  logic                           out_strobe_r;
  tas_pkg::out_word_t             out_word_r;

  logic [tas_pkg::OVAL_W-1:0]     frame_raw;
  logic [tas_pkg::OVAL_W-1:0]     frame_sel;
  tas_pkg::out_word_t             s1_word;
  tas_pkg::out_word_t             last_word;

  // order table, row per slot
  assign waddr = MAW'(32'(ord_wr.slot) * ORDER_DEPTH + 32'(ord_wr.position));
  assign raddr = MAW'(32'(rec.slot) * ORDER_DEPTH + 32'(rec.pos));

  always_ff @(posedge clk) begin
    if (ord_wr.en) begin
      order_mem[waddr] <= ord_wr.value;
    end
    rdata_r <= order_mem[raddr];
  end

  // stage 1 holds the record while the table word comes back
  always_ff @(posedge clk) begin
    s1_slot_r    <= rec.slot[tas_pkg::SLOT_W-1:0];
    s1_tile_r    <= rec.tile;
    s1_frames_r  <= rec.frames;
    s1_ordered_r <= rec.ordered;
    s1_pos_r     <= rec.pos;
  end

  // resolve the frame; out-of-range order values show frame 0
  assign frame_raw = s1_ordered_r ? rdata_r : tas_pkg::OVAL_W'(s1_pos_r);
  assign frame_sel = (frame_raw >= tas_pkg::OVAL_W'(s1_frames_r)) ? '0 : frame_raw;

  always_comb begin
    s1_word             = '0;
    s1_word.updated     = 1'b1;
    s1_word.source_slot = s1_slot_r;
    s1_word.target_tile = s1_tile_r;
    s1_word.frame_index = frame_sel[tas_pkg::FIDX_W-1:0];
  end

  // closing word: the held one, or an empty one when no slot advanced
  always_comb begin
    if (pend_valid_r) begin
      last_word = pend_r;
    end else begin
      last_word = '0;
    end
    last_word.last = 1'b1;
  end

  // one word held back so the final one can carry last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      end_d_r      <= 1'b0;
      pend_valid_r <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      s1_valid_r   <= rec.valid;
      end_d_r      <= chain_end;
      out_strobe_r <= 1'b0;
      if (s1_valid_r) begin
        if (pend_valid_r) begin
          out_strobe_r <= 1'b1;
        end
        pend_valid_r <= 1'b1;
      end else if (end_d_r) begin
        out_strobe_r <= 1'b1;
        pend_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      pend_r     <= s1_word;
      out_word_r <= pend_r;
    end else if (end_d_r) begin
      out_word_r <= last_word;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;
  assign done       = end_d_r;

endmodule

// File: sv/tile_animation_sequencer.sv
// Channel   Handshake               Payload
// input     start / busy            in_word  (tas_pkg::in_word_t)
// result    out_strobe              out_word (tas_pkg::out_word_t)
//
// Define, order write and clear-all leave busy low.
// A tick goes through the start register, then a token walks the slot
// cells one per cycle, then the order-table read and the held-back last
// word. Results appear one per cycle at most, in slot order.
// Reset is synchronous; all slots come up invalid with zero counters.
// The receiver cannot stall: each word is flagged by out_strobe for one cycle only.
module tile_animation_sequencer #(
  parameter int NUM_SLOTS   = 8,
  parameter int ORDER_DEPTH = 32,
  parameter int MAX_FRAMES  = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tas_pkg::in_word_t   in_word,
  output logic                out_strobe,
  output tas_pkg::out_word_t  out_word
);

  logic                       busy_r;
  logic                       go_r;
  logic                       accept;
  logic                       done;
  logic [NUM_SLOTS:0]         tok;
  tas_pkg::slot_rec_t         recs [NUM_SLOTS];
  tas_pkg::slot_rec_t         rec_any;
  tas_pkg::cell_cmd_t         cmd;
  tas_pkg::ord_wr_t           ord_wr;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  // slot commands with saturated frame count and order length
  always_comb begin
    cmd           = '0;
    cmd.define_en = accept && (in_word.kind == tas_pkg::KIND_DEFINE);
    cmd.clear_en  = accept && (in_word.kind == tas_pkg::KIND_CLEAR);
    cmd.slot      = in_word.slot;
    cmd.tile      = in_word.tile_index;
    cmd.period    = in_word.frame_time;
    cmd.frames    = (32'(in_word.frame_count) > MAX_FRAMES) ?
                    tas_pkg::FRAMES_W'(MAX_FRAMES) : in_word.frame_count;
    cmd.olen      = (32'(in_word.order_length) > ORDER_DEPTH) ?
                    tas_pkg::OLEN_W'(ORDER_DEPTH) : in_word.order_length;
  end

  // order table write, out-of-range slot or position dropped
  always_comb begin
    ord_wr          = '0;
    ord_wr.en       = accept && (in_word.kind == tas_pkg::KIND_ORDER) &&
                      (32'(in_word.slot) < NUM_SLOTS) &&
                      (32'(in_word.order_position) < ORDER_DEPTH);
    ord_wr.slot     = in_word.slot;
    ord_wr.position = in_word.order_position;
    ord_wr.value    = in_word.order_value;
  end

  // tick control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      go_r   <= 1'b0;
    end else begin
      go_r <= accept && (in_word.kind == tas_pkg::KIND_TICK);
      if (accept && (in_word.kind == tas_pkg::KIND_TICK)) begin
        busy_r <= 1'b1;
      end else if (done) begin
        busy_r <= 1'b0;
      end
    end
  end

  // chain of slot cells, token handed along
  assign tok[0] = go_r;

  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
    tas_cell #(
      .SLOT_ID(k)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (cmd),
      .tok_in (tok[k]),
      .tok_out(tok[k+1]),
      .rec    (recs[k])
    );
  end

  // at most one cell holds the token, so OR merges the records
  always_comb begin
    rec_any = '0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      rec_any = rec_any | recs[k];
    end
  end

  tas_emit #(
    .NUM_SLOTS  (NUM_SLOTS),
    .ORDER_DEPTH(ORDER_DEPTH)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .ord_wr    (ord_wr),
    .rec       (rec_any),
    .chain_end (tok[NUM_SLOTS]),
    .out_strobe(out_strobe),
    .out_word  (out_word),
    .done      (done)
  );

endmodule

// File: sim/tile_animation_sequencer_checker.sv
`timescale 1ns / 1ps

// Watches both channels, predicts the frame updates of each accepted word
// and compares every result word against the oldest prediction.
module tile_frame_checker #(
  parameter int NUM_SLOTS   = 8,
  parameter int ORDER_DEPTH = 32,
  parameter int MAX_FRAMES  = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  tas_pkg::in_word_t  in_word,
  input  logic               out_strobe,
  input  tas_pkg::out_word_t out_word,
  output int                 mismatches,
  output int                 pending
);

  // predicted slot state
  logic                         anim_live   [NUM_SLOTS];
  logic [tas_pkg::TILE_W-1:0]   anim_tile   [NUM_SLOTS];
  logic [tas_pkg::FRAMES_W-1:0] anim_frames [NUM_SLOTS];
  logic [tas_pkg::TIME_W-1:0]   anim_period [NUM_SLOTS];
  logic [tas_pkg::OLEN_W-1:0]   anim_olen   [NUM_SLOTS];
  logic [tas_pkg::TIME_W-1:0]   tick_cnt    [NUM_SLOTS];
  logic [tas_pkg::POS_W-1:0]    play_pos    [NUM_SLOTS];
  logic [tas_pkg::OVAL_W-1:0]   frame_order [NUM_SLOTS][ORDER_DEPTH];

  // frame updates still owed by the block, oldest first
  tas_pkg::out_word_t frames_due[$];
  tas_pkg::out_word_t want;

  function automatic void halt_slots();
    for (int s = 0; s < NUM_SLOTS; s++) begin
      anim_live[s] = 1'b0;
      tick_cnt[s]  = '0;
      play_pos[s]  = '0;
    end
  endfunction

  task automatic predict_word(input tas_pkg::in_word_t w);
    int unsigned fc, ol, total, pos, frame, n;
    tas_pkg::out_word_t batch [8];
    n = 0;
    case (w.kind)
      tas_pkg::KIND_DEFINE: begin
        fc = (w.frame_count > MAX_FRAMES) ? MAX_FRAMES : w.frame_count;
        ol = (w.order_length > ORDER_DEPTH) ? ORDER_DEPTH : w.order_length;
        if (w.slot < NUM_SLOTS) begin
          anim_live[w.slot]   = 1'b1;
          anim_tile[w.slot]   = w.tile_index;
          anim_frames[w.slot] = tas_pkg::FRAMES_W'(fc);
          anim_period[w.slot] = w.frame_time;
          anim_olen[w.slot]   = tas_pkg::OLEN_W'(ol);
          tick_cnt[w.slot]    = '0;
          play_pos[w.slot]    = '0;
        end
      end
      tas_pkg::KIND_ORDER: begin
        if (w.slot < NUM_SLOTS && w.order_position < ORDER_DEPTH)
          frame_order[w.slot][w.order_position] = w.order_value;
      end
      tas_pkg::KIND_CLEAR: halt_slots();
      default: begin
        // tick: every live slot counts, in ascending slot order
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (anim_live[s]) begin
            tick_cnt[s] = tick_cnt[s] + 1'b1;
            if (tick_cnt[s] >= anim_period[s]) begin
              tick_cnt[s] = '0;
              total = (anim_olen[s] != 0) ? anim_olen[s] : anim_frames[s];
              pos = play_pos[s] + 1;
              if (pos >= total) pos = 0;
              play_pos[s] = tas_pkg::POS_W'(pos);
              frame = (anim_olen[s] != 0) ? frame_order[s][pos] : pos;
              // out-of-range frame number shows frame 0
              if (frame >= anim_frames[s]) frame = 0;
              if (n < 8) begin
                batch[n].updated     = 1'b1;
                batch[n].source_slot = tas_pkg::SLOT_W'(s);
                batch[n].target_tile = anim_tile[s];
                batch[n].frame_index = tas_pkg::FIDX_W'(frame);
                batch[n].last        = 1'b0;
                n++;
              end
            end
          end
        end
        // no slot advanced: a single empty word
        if (n == 0) begin
          batch[0] = '0;
          n = 1;
        end
        batch[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) frames_due = {frames_due, batch[i]};
      end
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned exp_v, input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      halt_slots();
      frames_due.delete();
      mismatches = 0;
    end else begin
      // results first: a word's own results never share its accept edge
      if (out_strobe) begin
        if (frames_due.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %h", $time, out_word);
          mismatches++;
        end else begin
          want = frames_due.pop_front();
          check_field("updated", want.updated, out_word.updated);
          check_field("source_slot", want.source_slot, out_word.source_slot);
          check_field("target_tile", want.target_tile, out_word.target_tile);
          check_field("frame_index", want.frame_index, out_word.frame_index);
          check_field("last", want.last, out_word.last);
        end
      end
      if (start && !busy) predict_word(in_word);
    end
    pending = frames_due.size();
  end

endmodule

// File: sim/tile_animation_sequencer_test.sv
`timescale 1ns / 1ps

module tile_animation_sequencer_test;

  localparam int NUM_SLOTS    = 8;
  localparam int ORDER_DEPTH  = 32;
  localparam int MAX_FRAMES   = 64;
  localparam int WORD_GOAL    = 270;
  localparam int DRAIN_CYCLES = NUM_SLOTS + 12;

  logic               clk     = 1'b0;
  logic               rst_n   = 1'b0;
  logic               start   = 1'b0;
  tas_pkg::in_word_t  in_word = '0;
  logic               busy;
  logic               out_strobe;
  tas_pkg::out_word_t out_word;
  int                 mismatches;
  int                 pending;

  // order entries written so far, per slot
  logic [ORDER_DEPTH-1:0] order_known [NUM_SLOTS];
  int accepted;
  bit calm;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  tile_animation_sequencer #(
    .NUM_SLOTS(NUM_SLOTS), .ORDER_DEPTH(ORDER_DEPTH), .MAX_FRAMES(MAX_FRAMES)
  ) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_strobe(out_strobe), .out_word(out_word)
  );

  tile_frame_checker #(
    .NUM_SLOTS(NUM_SLOTS), .ORDER_DEPTH(ORDER_DEPTH), .MAX_FRAMES(MAX_FRAMES)
  ) frame_check (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_strobe(out_strobe), .out_word(out_word),
    .mismatches(mismatches), .pending(pending)
  );

  function automatic tas_pkg::in_word_t make_word(input logic [1:0] kind, input int slot,
                                                  input int tile, input int fc, input int ft,
                                                  input int ol, input int op, input int ov);
    tas_pkg::in_word_t w;
    w.kind           = kind;
    w.slot           = tas_pkg::SLOT_W'(slot);
    w.tile_index     = tas_pkg::TILE_W'(tile);
    w.frame_count    = tas_pkg::FRAMES_W'(fc);
    w.frame_time     = tas_pkg::TIME_W'(ft);
    w.order_length   = tas_pkg::OLEN_W'(ol);
    w.order_position = tas_pkg::OPOS_W'(op);
    w.order_value    = tas_pkg::OVAL_W'(ov);
    return w;
  endfunction

  // all fields random, kind forced
  function automatic tas_pkg::in_word_t random_word(input logic [1:0] kind);
    logic [63:0] raw;
    tas_pkg::in_word_t w;
    raw = {$urandom, $urandom};
    w = raw[$bits(tas_pkg::in_word_t)-1:0];
    w.kind = kind;
    return w;
  endfunction

  // mostly frame numbers that can exist, some beyond any frame count
  function automatic logic [tas_pkg::OVAL_W-1:0] pick_order_value();
    if ($urandom_range(0, 99) < 75) return tas_pkg::OVAL_W'($urandom_range(0, 63));
    return tas_pkg::OVAL_W'($urandom_range(0, 255));
  endfunction

  // short periods and frame counts so that slots advance often
  function automatic tas_pkg::in_word_t random_define(input bit full_order);
    tas_pkg::in_word_t w;
    int r;
    w = random_word(tas_pkg::KIND_DEFINE);
    r = $urandom_range(0, 99);
    if (r < 70)      w.frame_count = tas_pkg::FRAMES_W'($urandom_range(2, 8));
    else if (r < 85) w.frame_count = tas_pkg::FRAMES_W'($urandom_range(9, 64));
    else if (r < 95) w.frame_count = tas_pkg::FRAMES_W'($urandom_range(65, 127));
    else             w.frame_count = tas_pkg::FRAMES_W'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 60)      w.frame_time = tas_pkg::TIME_W'($urandom_range(1, 3));
    else if (r < 80) w.frame_time = '0;
    else if (r < 95) w.frame_time = tas_pkg::TIME_W'($urandom_range(4, 12));
    else             w.frame_time = tas_pkg::TIME_W'($urandom_range(0, 65535));
    r = $urandom_range(0, 99);
    if (full_order || r >= 95) w.order_length = tas_pkg::OLEN_W'($urandom_range(32, 63));
    else if (r < 50)           w.order_length = '0;
    else if (r < 85)           w.order_length = tas_pkg::OLEN_W'($urandom_range(1, 8));
    else                       w.order_length = tas_pkg::OLEN_W'($urandom_range(9, 31));
    return w;
  endfunction

  // hand one word to the block, with a random pause in front unless calm
  task automatic push_word(input tas_pkg::in_word_t w);
    while (!calm && $urandom_range(0, 99) < 23) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (w.kind == tas_pkg::KIND_ORDER) order_known[w.slot][w.order_position] = 1'b1;
    accepted++;
  endtask

  // fill every order entry the slot will read before it goes live
  task automatic define_slot(input tas_pkg::in_word_t w);
    int need;
    need = (w.order_length > ORDER_DEPTH) ? ORDER_DEPTH : w.order_length;
    for (int p = 0; p < need; p++)
      if (!order_known[w.slot][p])
        push_word(make_word(tas_pkg::KIND_ORDER, w.slot, 0, 0, 0, 0, p,
                            pick_order_value()));
    push_word(w);
  endtask

  initial begin
    tas_pkg::in_word_t w;
    int r;
    bit first;
    for (int s = 0; s < NUM_SLOTS; s++) order_known[s] = '0;
    accepted = 0;
    calm = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty ticks, saturation, short frame counts, odd orders
    push_word(make_word(tas_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    push_word(make_word(tas_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0));
    push_word(make_word(tas_pkg::KIND_ORDER, 0, 0, 0, 0, 0, 0, 2));
    push_word(make_word(tas_pkg::KIND_ORDER, 0, 0, 0, 0, 0, 1, 200));
    push_word(make_word(tas_pkg::KIND_ORDER, 0, 0, 0, 0, 0, 2, 3));
    push_word(make_word(tas_pkg::KIND_ORDER, 7, 0, 0, 0, 0, 31, 255));
    define_slot(make_word(tas_pkg::KIND_DEFINE, 0, 16'hFFFF, 4, 1, 3, 0, 0));
    define_slot(make_word(tas_pkg::KIND_DEFINE, 7, 0, 0, 0, 0, 0, 0));
    define_slot(make_word(tas_pkg::KIND_DEFINE, 3, 16'h1234, 127, 2, 0, 0, 0));
    define_slot(make_word(tas_pkg::KIND_DEFINE, 5, 16'h00FF, 1, 65535, 0, 0, 0));
    repeat (5) push_word(make_word(tas_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0));
    define_slot(make_word(tas_pkg::KIND_DEFINE, 0, 16'hA5A5, 4, 1, 1, 0, 0));
    push_word(make_word(tas_pkg::KIND_TICK, 7, 16'hFFFF, 127, 65535, 63, 31, 255));
    push_word(make_word(tas_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    push_word(make_word(tas_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0));

    // random: first define always uses the full order table
    first = 1'b1;
    while (accepted < WORD_GOAL) begin
      calm = (accepted >= 120 && accepted < 180);
      r = $urandom_range(0, 99);
      if (first || (r >= 45 && r < 70)) begin
        define_slot(random_define(first));
        first = 1'b0;
      end else if (r < 45) begin
        push_word(random_word(tas_pkg::KIND_TICK));
      end else if (r < 95) begin
        w = random_word(tas_pkg::KIND_ORDER);
        w.order_value = pick_order_value();
        push_word(w);
      end else begin
        push_word(random_word(tas_pkg::KIND_CLEAR));
      end
    end
    start <= 1'b0;

    // drain outstanding results
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tile_animation_sequencer_test: done, clean");
    end else begin
      $display("tile_animation_sequencer_test: done, errors");
    end
    $finish;
  end

  // hang guard
  initial begin
    #5_000_000;
    $display("tile_animation_sequencer_test: done, errors");
    $finish;
  end

endmodule
